// ===== rtl/greedy_spectral_cosine_defines.svh =====
// ----------------------------------------------------------------------------
// greedy_spectral_cosine_defines
// Assertion macros shared by the checker of the spectral cosine block.
// ----------------------------------------------------------------------------
`ifndef GREEDY_SPECTRAL_COSINE_DEFINES_SVH
`define GREEDY_SPECTRAL_COSINE_DEFINES_SVH

// Check a property on every edge outside reset
`define GSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every edge, reset included
`define GSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/gsc_pkg.sv =====
// ----------------------------------------------------------------------------
// gsc_pkg
// Types and constants of the greedy spectral cosine block.
// ----------------------------------------------------------------------------
package gsc_pkg;

  localparam int MZ_W        = 32;
  localparam int INT_W       = 16;
  localparam int SCORE_W     = 16;
  localparam int MATCH_W     = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;
  // signed width that holds m/z plus or minus a 32-bit offset
  localparam int CMP_W       = 35;
  // bits of the square-root search and its bit counter
  localparam int ROOT_BITS   = 16;
  localparam int ROOT_BIT_W  = 4;
  // Q1.15 score squared gives 2^30
  localparam int FRAC_SHIFT  = 30;

  localparam logic [MZ_W-1:0]    TOL_RESET = 32'd1638;
  localparam logic [SCORE_W-1:0] SCORE_ONE = 16'd32768;

  typedef enum logic [1:0] {
    OP_ADD_REF   = 2'd0,
    OP_ADD_QRY   = 2'd1,
    OP_COMPUTE   = 2'd2,
    OP_CLEAR_REF = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOL   = 1'b0,
    CFG_SHIFT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVAL,
    ST_MUL_T,
    ST_MUL_S,
    ST_ROOT_A,
    ST_ROOT_B,
    ST_FINISH
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_READ,
    CMD_NEXT_ROW,
    CMD_EVAL,
    CMD_MUL_T_INIT,
    CMD_MUL_STEP,
    CMD_MUL_S_INIT,
    CMD_ROOT_INIT,
    CMD_ROOT_TRY,
    CMD_ROOT_KEEP,
    CMD_FINISH
  } cmd_e;

  typedef struct packed {
    logic walk_end;
    logic row_end;
    logic found;
    logic mul_done;
    logic root_last;
    logic norm_zero;
    logic out_free;
  } gsc_status_t;

endpackage

// ===== rtl/gsc_if.sv =====
// ----------------------------------------------------------------------------
// gsc_if
// Valid/ready channels of the spectral cosine block: peak input and score.
// ----------------------------------------------------------------------------
interface gsc_in_if;
  import gsc_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [MZ_W-1:0]   peak_mz;
  logic [INT_W-1:0]  peak_intensity;

  modport source (output valid, op, peak_mz, peak_intensity, input ready);
  modport sink   (input valid, op, peak_mz, peak_intensity, output ready);
endinterface

interface gsc_out_if;
  import gsc_pkg::*;
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] cosine_score;
  logic [MATCH_W-1:0] matched_peaks;
  logic               peaks_dropped;

  modport source (output valid, cosine_score, matched_peaks, peaks_dropped, input ready);
  modport sink   (input valid, cosine_score, matched_peaks, peaks_dropped, output ready);
endinterface

// ===== rtl/gsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsc_ctrl
// Sequencer: peak walk, norm multiplies, square-root search and result.
// ----------------------------------------------------------------------------
module gsc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_acc_i,
  input  logic [1:0]           op_i,
  input  gsc_pkg::gsc_status_t status_i,
  output logic                 in_ready_o,
  output gsc_pkg::cmd_e        cmd_o
);
  import gsc_pkg::*;

  state_e state_q, state_d;

  // hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc_i && (op_e'(op_i) == OP_COMPUTE)) state_d = ST_FETCH;
      end
      ST_FETCH: begin
        if (status_i.walk_end) begin
          state_d = status_i.found ? ST_MUL_T : ST_FINISH;
        end else if (!status_i.row_end) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: state_d = ST_FETCH;
      ST_MUL_T: begin
        if (status_i.mul_done) state_d = ST_MUL_S;
      end
      ST_MUL_S: begin
        if (status_i.mul_done) state_d = status_i.norm_zero ? ST_FINISH : ST_ROOT_A;
      end
      ST_ROOT_A: state_d = ST_ROOT_B;
      ST_ROOT_B: begin
        if (status_i.root_last) state_d = ST_FINISH;
        else state_d = ST_ROOT_A;
      end
      ST_FINISH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = CMD_NONE;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_FETCH: begin
        if (status_i.walk_end) begin
          if (status_i.found) cmd_o = CMD_MUL_T_INIT;
        end else if (status_i.row_end) begin
          cmd_o = CMD_NEXT_ROW;
        end else begin
          cmd_o = CMD_READ;
        end
      end
      ST_EVAL: cmd_o = CMD_EVAL;
      ST_MUL_T: cmd_o = status_i.mul_done ? CMD_MUL_S_INIT : CMD_MUL_STEP;
      ST_MUL_S: cmd_o = status_i.mul_done ? CMD_ROOT_INIT : CMD_MUL_STEP;
      ST_ROOT_A: cmd_o = CMD_ROOT_TRY;
      ST_ROOT_B: cmd_o = CMD_ROOT_KEEP;
      ST_FINISH: begin
        if (status_i.out_free) cmd_o = CMD_FINISH;
      end
      default: cmd_o = CMD_NONE;
    endcase
  end

endmodule

// ===== rtl/gsc_datapath.sv =====
// ----------------------------------------------------------------------------
// gsc_datapath
// Peak stores, match walk, shift-add multiplier, square-root search, output.
// ----------------------------------------------------------------------------
module gsc_datapath #(
  parameter int MAX_PEAKS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gsc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gsc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_acc_i,
  input  logic [1:0]                         op_i,
  input  logic [gsc_pkg::MZ_W-1:0]           peak_mz_i,
  input  logic [gsc_pkg::INT_W-1:0]          peak_intensity_i,
  input  gsc_pkg::cmd_e                      cmd_i,
  output gsc_pkg::gsc_status_t               status_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [gsc_pkg::SCORE_W-1:0]        cosine_score_o,
  output logic [gsc_pkg::MATCH_W-1:0]        matched_peaks_o,
  output logic                               peaks_dropped_o
);
  import gsc_pkg::*;

  localparam int IDX_W  = $clog2(MAX_PEAKS);
  localparam int CNT_W  = $clog2(MAX_PEAKS + 1);
  localparam int AW     = 2 * INT_W + CNT_W;
  localparam int MW     = 2 * AW;
  localparam int PW     = MW + 2 * ROOT_BITS;
  localparam int MCNT_W = $clog2(AW + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PEAKS);

  // peak stores
  logic [MZ_W-1:0]  ref_mz_mem  [MAX_PEAKS];
  logic [INT_W-1:0] ref_int_mem [MAX_PEAKS];
  logic [MZ_W-1:0]  qry_mz_mem  [MAX_PEAKS];
  logic [INT_W-1:0] qry_int_mem [MAX_PEAKS];
  logic [MZ_W-1:0]  rmz_rd_q, qmz_rd_q;
  logic [INT_W-1:0] rint_rd_q, qint_rd_q;

  // configuration and spectrum state
  logic [MZ_W-1:0]  tol_q, shift_q;
  logic [CNT_W-1:0] rcnt_q, qcnt_q;
  logic             rovf_q, qovf_q;
  logic [AW-1:0]    sr_q, sq_q;

  // walk state
  logic [CNT_W-1:0]     i_q, j_q, low_q, match_q;
  logic                 found_q, cur_used_q;
  logic [MAX_PEAKS-1:0] qused_q;
  logic [AW-1:0]        acc_q;

  // multiplier and root search
  logic [MW-1:0]         mul_a_q, mul_acc_q, t_q;
  logic [AW-1:0]         mul_b_q;
  logic [MCNT_W-1:0]     mul_cnt_q;
  logic [PW-1:0]         r_q, p_q, qs_q, tb_q, trial_q;
  logic [ROOT_BITS-1:0]  k_q;
  logic [ROOT_BIT_W-1:0] bit_q;

  // output register
  logic               out_valid_q, dropped_q;
  logic [SCORE_W-1:0] score_q;
  logic [MATCH_W-1:0] matched_q;

  logic                    add_ref, add_qry;
  logic [2*INT_W-1:0]      load_sq, pair_prod;
  logic signed [CMP_W-1:0] qmz_x, rmz_x, shift_x, tol_x, m2, lo_b, hi_b;

  assign add_ref = in_acc_i && (op_e'(op_i) == OP_ADD_REF) && (rcnt_q < MAX_CNT);
  assign add_qry = in_acc_i && (op_e'(op_i) == OP_ADD_QRY) && (qcnt_q < MAX_CNT);
  assign load_sq = (2*INT_W)'(peak_intensity_i) * (2*INT_W)'(peak_intensity_i);
  assign pair_prod = (2*INT_W)'(rint_rd_q) * (2*INT_W)'(qint_rd_q);

  // match window on the fetched pair
  always_comb begin
    qmz_x   = {{(CMP_W-MZ_W){1'b0}}, qmz_rd_q};
    rmz_x   = {{(CMP_W-MZ_W){1'b0}}, rmz_rd_q};
    tol_x   = {{(CMP_W-MZ_W){1'b0}}, tol_q};
    shift_x = {{(CMP_W-MZ_W){shift_q[MZ_W-1]}}, shift_q};
    m2      = qmz_x + shift_x;
    lo_b    = rmz_x - tol_x;
    hi_b    = rmz_x + tol_x;
  end

  // reference store
  always_ff @(posedge clk_i) begin
    if (add_ref) begin
      ref_mz_mem[rcnt_q[IDX_W-1:0]]  <= peak_mz_i;
      ref_int_mem[rcnt_q[IDX_W-1:0]] <= peak_intensity_i;
    end
    if (cmd_i == CMD_READ) begin
      rmz_rd_q  <= ref_mz_mem[i_q[IDX_W-1:0]];
      rint_rd_q <= ref_int_mem[i_q[IDX_W-1:0]];
    end
  end

  // query store
  always_ff @(posedge clk_i) begin
    if (add_qry) begin
      qry_mz_mem[qcnt_q[IDX_W-1:0]]  <= peak_mz_i;
      qry_int_mem[qcnt_q[IDX_W-1:0]] <= peak_intensity_i;
    end
    if (cmd_i == CMD_READ) begin
      qmz_rd_q  <= qry_mz_mem[j_q[IDX_W-1:0]];
      qint_rd_q <= qry_int_mem[j_q[IDX_W-1:0]];
    end
  end

  // configuration, loads and the match walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q       <= TOL_RESET;
      shift_q     <= '0;
      rcnt_q      <= '0;
      qcnt_q      <= '0;
      rovf_q      <= 1'b0;
      qovf_q      <= 1'b0;
      sr_q        <= '0;
      sq_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      low_q       <= '0;
      match_q     <= '0;
      found_q     <= 1'b0;
      cur_used_q  <= 1'b0;
      qused_q     <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_TOL:   tol_q   <= cfg_data_i;
          CFG_SHIFT: shift_q <= cfg_data_i;
          default:   ;
        endcase
      end

      if (in_acc_i) begin
        unique case (op_e'(op_i))
          OP_ADD_REF: begin
            if (rcnt_q < MAX_CNT) begin
              rcnt_q <= rcnt_q + CNT_W'(1);
              sr_q   <= sr_q + AW'(load_sq);
            end else begin
              rovf_q <= 1'b1;
            end
          end
          OP_ADD_QRY: begin
            if (qcnt_q < MAX_CNT) begin
              qcnt_q <= qcnt_q + CNT_W'(1);
              sq_q   <= sq_q + AW'(load_sq);
            end else begin
              qovf_q <= 1'b1;
            end
          end
          OP_COMPUTE: begin
            i_q        <= '0;
            j_q        <= '0;
            low_q      <= '0;
            match_q    <= '0;
            found_q    <= 1'b0;
            cur_used_q <= 1'b0;
            qused_q    <= '0;
            acc_q      <= '0;
          end
          OP_CLEAR_REF: begin
            rcnt_q <= '0;
            rovf_q <= 1'b0;
            sr_q   <= '0;
          end
          default: ;
        endcase
      end

      unique case (cmd_i)
        CMD_NEXT_ROW: begin
          i_q        <= i_q + CNT_W'(1);
          j_q        <= low_q;
          cur_used_q <= 1'b0;
        end
        CMD_EVAL: begin
          if (m2 > hi_b) begin
            // past the window: advance to the next reference peak
            i_q        <= i_q + CNT_W'(1);
            j_q        <= low_q;
            cur_used_q <= 1'b0;
          end else if (m2 < lo_b) begin
            low_q <= j_q;
            j_q   <= j_q + CNT_W'(1);
          end else begin
            found_q <= 1'b1;
            if (!cur_used_q && !qused_q[j_q[IDX_W-1:0]]) begin
              acc_q                      <= acc_q + AW'(pair_prod);
              cur_used_q                 <= 1'b1;
              qused_q[j_q[IDX_W-1:0]]    <= 1'b1;
              match_q                    <= match_q + CNT_W'(1);
            end
            j_q <= j_q + CNT_W'(1);
          end
        end
        CMD_FINISH: begin
          // drop the query spectrum
          qcnt_q <= '0;
          qovf_q <= 1'b0;
          sq_q   <= '0;
        end
        default: ;
      endcase

      if ((cmd_i == CMD_FINISH) && found_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // norm multiplies and bitwise square-root search
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_MUL_T_INIT: begin
        mul_a_q   <= MW'(sr_q);
        mul_b_q   <= sq_q;
        mul_acc_q <= '0;
        mul_cnt_q <= '0;
      end
      CMD_MUL_STEP: begin
        if (mul_b_q[0]) mul_acc_q <= mul_acc_q + mul_a_q;
        mul_a_q   <= mul_a_q << 1;
        mul_b_q   <= mul_b_q >> 1;
        mul_cnt_q <= mul_cnt_q + MCNT_W'(1);
      end
      CMD_MUL_S_INIT: begin
        t_q       <= mul_acc_q;
        mul_a_q   <= MW'(acc_q);
        mul_b_q   <= acc_q;
        mul_acc_q <= '0;
        mul_cnt_q <= '0;
      end
      CMD_ROOT_INIT: begin
        r_q   <= PW'(mul_acc_q) << FRAC_SHIFT;
        tb_q  <= PW'(t_q) << (2 * (ROOT_BITS - 1));
        qs_q  <= '0;
        p_q   <= '0;
        k_q   <= '0;
        bit_q <= ROOT_BIT_W'(ROOT_BITS - 1);
      end
      CMD_ROOT_TRY: trial_q <= p_q + qs_q + tb_q;
      CMD_ROOT_KEEP: begin
        if (trial_q <= r_q) begin
          p_q  <= trial_q;
          k_q  <= k_q | (ROOT_BITS'(1) << bit_q);
          qs_q <= (qs_q + (tb_q << 1)) >> 1;
        end else begin
          qs_q <= qs_q >> 1;
        end
        tb_q  <= tb_q >> 2;
        bit_q <= bit_q - ROOT_BIT_W'(1);
      end
      CMD_FINISH: begin
        score_q   <= k_q;
        matched_q <= MATCH_W'(match_q);
        dropped_q <= rovf_q | qovf_q;
      end
      default: ;
    endcase
  end

  // status to the sequencer
  always_comb begin
    status_o.walk_end  = (i_q >= rcnt_q);
    status_o.row_end   = (j_q >= qcnt_q);
    status_o.found     = found_q;
    status_o.mul_done  = (mul_cnt_q == MCNT_W'(AW));
    status_o.root_last = (bit_q == '0);
    status_o.norm_zero = (t_q == '0);
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o     = out_valid_q;
  assign cosine_score_o  = score_q;
  assign matched_peaks_o = matched_q;
  assign peaks_dropped_o = dropped_q;

endmodule

// ===== rtl/greedy_spectral_cosine.sv =====
// ----------------------------------------------------------------------------
// greedy_spectral_cosine
// Greedy cosine score of a query spectrum against a stored reference.
// ----------------------------------------------------------------------------
// Usage: peaks enter on in_i with op 0 (reference) or 1 (query), one transfer
// per cycle while in_i.ready is high. Op 3 empties the reference. Op 2 scores
// the query against the reference, then empties the query; in_i.ready stays
// low until the score is handed to the output register. A compute runs the
// match walk, the serial shift-add multiplier for the two norm products (each
// a load and then the shift-add steps), the bitwise square-root search, and a
// finish step. A result appears on out_o only when at least one pair fell
// within the tolerance window. While out_o is stalled, loads are still
// accepted; a following compute waits at its end for the output register.
// Configuration (tolerance, shift) is written on cfg_we_i; the user must write
// it only while idle, which the block itself does not enforce.
// Reset empties both spectra, clears the flags and restores the configuration
// registers.
// ----------------------------------------------------------------------------
module greedy_spectral_cosine #(
  parameter int MAX_PEAKS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gsc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  gsc_in_if.sink                         in_i,
  gsc_out_if.source                      out_o
);
  import gsc_pkg::*;

  logic        in_ready, in_acc;
  cmd_e        cmd;
  gsc_status_t status;

  assign in_acc   = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  gsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_acc_i   (in_acc),
    .op_i       (in_i.op),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  gsc_datapath #(
    .MAX_PEAKS (MAX_PEAKS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_acc_i         (in_acc),
    .op_i             (in_i.op),
    .peak_mz_i        (in_i.peak_mz),
    .peak_intensity_i (in_i.peak_intensity),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .cosine_score_o   (out_o.cosine_score),
    .matched_peaks_o  (out_o.matched_peaks),
    .peaks_dropped_o  (out_o.peaks_dropped)
  );

endmodule

// ===== rtl/gsc_checker.sv =====
// ----------------------------------------------------------------------------
// gsc_checker
// Port-level checks of the spectral cosine block, bound to the top level.
// ----------------------------------------------------------------------------
`include "greedy_spectral_cosine_defines.svh"

module gsc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic [1:0]                   in_op_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [gsc_pkg::SCORE_W-1:0]  cosine_score_i,
  input logic [gsc_pkg::MATCH_W-1:0]  matched_peaks_i,
  input logic                         peaks_dropped_i
);
  import gsc_pkg::*;

  // stalled result holds
  `GSC_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(cosine_score_i) && $stable(matched_peaks_i) && $stable(peaks_dropped_i), "result changed while stalled")

  // no result once reset has been seen at an edge
  `GSC_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_i, "result valid in reset")

  // a compute transfer closes the input while it runs
  `GSC_ASSERT(a_compute_busy, in_valid_i && in_ready_i && (in_op_i == OP_COMPUTE) |=> !in_ready_i, "input open after compute")

  // a result has at least one pair and a score within one
  `GSC_ASSERT(a_result_range, out_valid_i |-> (matched_peaks_i != '0) && (cosine_score_i <= SCORE_ONE), "result out of range")

endmodule

bind greedy_spectral_cosine gsc_checker u_gsc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_op_i         (in_i.op),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .cosine_score_i  (out_o.cosine_score),
  .matched_peaks_i (out_o.matched_peaks),
  .peaks_dropped_i (out_o.peaks_dropped)
);
